// ===== hdl/alc_pkg.sv =====
`default_nettype none

package alc_pkg;

    // Configuration port geometry.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SECRET_FIRST     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECRET_SECOND    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECRET_THIRD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_HOLD_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_GAP_TICKS  = 3'd4;

    // Register reset values.
    localparam logic [3:0]  SECRET_FIRST_RST     = 4'd7;
    localparam logic [3:0]  SECRET_SECOND_RST    = 4'd5;
    localparam logic [3:0]  SECRET_THIRD_RST     = 4'd9;
    localparam logic [15:0] LIGHT_HOLD_TICKS_RST = 16'd25;
    localparam logic [7:0]  PRESS_GAP_TICKS_RST  = 8'd5;

    // Code entry limits.
    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [1:0] LAST_POS   = 2'd2;
    localparam int unsigned NUM_DIGITS = 3;

    localparam logic [15:0] LAMP_ELAPSED_MAX  = 16'hFFFF;
    localparam logic [7:0]  PRESS_ELAPSED_MAX = 8'hFF;

    typedef struct packed {
        logic [3:0]  secret_first;
        logic [3:0]  secret_second;
        logic [3:0]  secret_third;
        logic [15:0] light_hold_ticks;
        logic [7:0]  press_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic                        code_press;
        logic                        light_press;
        logic                        presence_seen;
    } t_tick;

    typedef struct packed {
        logic                              lamp_state;
        logic [15:0]                       lamp_elapsed;
        logic                              armed_state;
        logic                              siren_state;
        logic                              pending_presence_lamp;
        logic                              pending_presence_alarm;
        logic                              code_good_flag;
        logic [NUM_DIGITS-1:0][3:0]        entered_digits;
        logic [1:0]                        entry_index;
        logic [7:0]                        press_elapsed;
        logic                              press_active;
    } t_state;

    typedef struct packed {
        logic       light_on;
        logic       alarm_armed;
        logic       siren_on;
        logic [1:0] digit_position;
        logic [3:0] digit_value;
        logic       code_accepted;
        logic       code_rejected;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/alc_cfg_regs.sv =====
`default_nettype none

module alc_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr_en,
    input  wire logic [alc_pkg::CFG_INDEX_W-1:0]   i_index,
    input  wire logic [alc_pkg::CFG_DATA_W-1:0]    i_wdata,
    output alc_pkg::t_cfg                          o_cfg
);

    alc_pkg::t_cfg r_cfg;

    // Writes beyond the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.secret_first     <= alc_pkg::SECRET_FIRST_RST;
            r_cfg.secret_second    <= alc_pkg::SECRET_SECOND_RST;
            r_cfg.secret_third     <= alc_pkg::SECRET_THIRD_RST;
            r_cfg.light_hold_ticks <= alc_pkg::LIGHT_HOLD_TICKS_RST;
            r_cfg.press_gap_ticks  <= alc_pkg::PRESS_GAP_TICKS_RST;
        end else if (i_wr_en) begin
            unique case (i_index)
                alc_pkg::REG_SECRET_FIRST:     r_cfg.secret_first     <= i_wdata[3:0];
                alc_pkg::REG_SECRET_SECOND:    r_cfg.secret_second    <= i_wdata[3:0];
                alc_pkg::REG_SECRET_THIRD:     r_cfg.secret_third     <= i_wdata[3:0];
                alc_pkg::REG_LIGHT_HOLD_TICKS: r_cfg.light_hold_ticks <= i_wdata[15:0];
                alc_pkg::REG_PRESS_GAP_TICKS:  r_cfg.press_gap_ticks  <= i_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/alc_tick_logic.sv =====
`default_nettype none

module alc_tick_logic (
    input  wire alc_pkg::t_cfg    i_cfg,
    input  wire alc_pkg::t_state  i_state,
    input  wire alc_pkg::t_tick   i_tick,
    output alc_pkg::t_state  o_next,
    output alc_pkg::t_result o_result
);

    always_comb begin
        alc_pkg::t_state ns;
        logic            light_req;
        logic            code_req;
        logic            match;
        logic            accepted;
        logic            rejected;
        logic [3:0]      cur_digit;
        logic [3:0]      out_digit;

        ns        = i_state;
        accepted  = 1'b0;
        rejected  = 1'b0;
        match     = 1'b0;
        cur_digit = 4'd0;
        out_digit = 4'd0;

        // Button events are always consumed in the tick they arrive.
        code_req  = i_tick.code_press;
        light_req = i_tick.light_press;
        if (i_tick.presence_seen) begin
            ns.pending_presence_lamp  = 1'b1;
            ns.pending_presence_alarm = 1'b1;
        end

        if (i_state.lamp_state && (i_state.lamp_elapsed != alc_pkg::LAMP_ELAPSED_MAX)) begin
            ns.lamp_elapsed = i_state.lamp_elapsed + 16'd1;
        end
        if (i_state.press_elapsed != alc_pkg::PRESS_ELAPSED_MAX) begin
            ns.press_elapsed = i_state.press_elapsed + 8'd1;
        end

        // Light machine.
        if (!i_state.lamp_state) begin
            if (ns.pending_presence_lamp || light_req) begin
                ns.lamp_state            = 1'b1;
                ns.pending_presence_lamp = 1'b0;
                ns.lamp_elapsed          = 16'd0;
            end
        end else if (light_req) begin
            ns.lamp_state = 1'b0;
        end else if (ns.pending_presence_lamp) begin
            ns.pending_presence_lamp = 1'b0;
            ns.lamp_elapsed          = 16'd0;
        end else if (ns.lamp_elapsed > i_cfg.light_hold_ticks) begin
            ns.lamp_state = 1'b0;
        end

        // Code machine.
        for (int i = 0; i < alc_pkg::NUM_DIGITS; i++) begin
            if (i_state.entry_index == 2'(i)) begin
                cur_digit = i_state.entered_digits[i];
            end
        end

        if (code_req) begin
            for (int i = 0; i < alc_pkg::NUM_DIGITS; i++) begin
                if (i_state.entry_index == 2'(i)) begin
                    ns.entered_digits[i] = (cur_digit < alc_pkg::DIGIT_MAX) ?
                                           cur_digit + 4'd1 : 4'd0;
                end
            end
            ns.press_elapsed  = 8'd0;
            ns.code_good_flag = 1'b0;
            ns.press_active   = 1'b1;
        end else if (i_state.press_active && (ns.press_elapsed > i_cfg.press_gap_ticks)) begin
            if (i_state.entry_index < alc_pkg::LAST_POS) begin
                ns.entry_index    = i_state.entry_index + 2'd1;
                ns.code_good_flag = 1'b0;
                ns.press_active   = 1'b0;
            end else begin
                match = (i_state.entered_digits[0] == i_cfg.secret_first)  &&
                        (i_state.entered_digits[1] == i_cfg.secret_second) &&
                        (i_state.entered_digits[2] == i_cfg.secret_third);
                ns.entry_index    = 2'd0;
                ns.entered_digits = '0;
                ns.press_active   = 1'b0;
                ns.code_good_flag = match;
                accepted          = match;
                rejected          = !match;
            end
        end

        // Alarm machine.
        if (!i_state.armed_state) begin
            if (ns.code_good_flag) begin
                ns.armed_state            = 1'b1;
                ns.pending_presence_alarm = 1'b0;
                ns.code_good_flag         = 1'b0;
            end
        end else if (ns.pending_presence_alarm) begin
            ns.siren_state            = 1'b1;
            ns.pending_presence_alarm = 1'b0;
        end else if (ns.code_good_flag) begin
            ns.armed_state            = 1'b0;
            ns.siren_state            = 1'b0;
            ns.pending_presence_alarm = 1'b0;
            ns.code_good_flag         = 1'b0;
        end

        for (int i = 0; i < alc_pkg::NUM_DIGITS; i++) begin
            if (ns.entry_index == 2'(i)) begin
                out_digit = ns.entered_digits[i];
            end
        end

        o_next                  = ns;
        o_result.light_on       = ns.lamp_state;
        o_result.alarm_armed    = ns.armed_state;
        o_result.siren_on       = ns.siren_state;
        o_result.digit_position = ns.entry_index;
        o_result.digit_value    = out_digit;
        o_result.code_accepted  = accepted;
        o_result.code_rejected  = rejected;
    end

endmodule

`default_nettype wire

// ===== hdl/alarm_light_code_controller.sv =====
// A tick transaction accepted into the input register is evaluated combinationally, and
// its result is captured in the output register on an advance of the pipe.
// Throughput: one tick transaction per cycle; the single output register and the
// input register advance together whenever the output side is not stalled.
// Reset: synchronous, active low; lamp, alarm, code entry and pending flags clear,
// and the configuration registers return to code 7-5-9, hold 25, gap 5.
`default_nettype none

module alarm_light_code_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input tick channel.
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_code_press,
    input  wire logic                            i_light_press,
    input  wire logic                            i_presence_seen,
    // Result channel.
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_light_on,
    output logic                                 o_alarm_armed,
    output logic                                 o_siren_on,
    output logic [1:0]                           o_digit_position,
    output logic [3:0]                           o_digit_value,
    output logic                                 o_code_accepted,
    output logic                                 o_code_rejected,
    // Configuration write port.
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [alc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [alc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    alc_pkg::t_cfg    cfg;
    alc_pkg::t_state  r_state;
    alc_pkg::t_state  n_state;
    alc_pkg::t_tick   r_tick;
    alc_pkg::t_result n_result;
    alc_pkg::t_result r_result;
    logic             r_tick_valid;
    logic             r_out_valid;
    logic             advance;

    alc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // The whole pipe moves as one: it holds only while a finished result sits in
    // the output register and the consumer stalls. A result waiting to be taken
    // does not block intake on its own, since the output register is freed in the
    // same cycle it is consumed.
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;

    // Input register: captures the tick events of one transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_valid <= 1'b0;
        end else if (advance) begin
            r_tick_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tick.code_press    <= i_code_press;
            r_tick.light_press   <= i_light_press;
            r_tick.presence_seen <= i_presence_seen;
        end
    end

    // The three state machines (light, then code, then alarm) are evaluated in
    // one pass of combinational logic against the registered tick.
    alc_tick_logic u_tick_logic (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_tick   (r_tick),
        .o_next   (n_state),
        .o_result (n_result)
    );

    // Machine state only moves when a valid tick is evaluated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance && r_tick_valid) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_tick_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_tick_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_light_on       = r_result.light_on;
    assign o_alarm_armed    = r_result.alarm_armed;
    assign o_siren_on       = r_result.siren_on;
    assign o_digit_position = r_result.digit_position;
    assign o_digit_value    = r_result.digit_value;
    assign o_code_accepted  = r_result.code_accepted;
    assign o_code_rejected  = r_result.code_rejected;

endmodule

`default_nettype wire

// ===== bench/alarm_light_code_controller_tb.sv =====
`default_nettype none

module alarm_light_code_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import alc_pkg::*;

    // Clock, reset and every block input start from a known value.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic tick_valid = 1'b0;
    logic code_press = 1'b0;
    logic light_press = 1'b0;
    logic presence_seen = 1'b0;
    logic result_stall = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic tick_stall;
    logic result_valid;
    logic light_on;
    logic alarm_armed;
    logic siren_on;
    logic [1:0] digit_position;
    logic [3:0] digit_value;
    logic code_accepted;
    logic code_rejected;

    alarm_light_code_controller u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (tick_valid),
        .o_in_stall       (tick_stall),
        .i_code_press     (code_press),
        .i_light_press    (light_press),
        .i_presence_seen  (presence_seen),
        .o_out_valid      (result_valid),
        .i_out_stall      (result_stall),
        .o_light_on       (light_on),
        .o_alarm_armed    (alarm_armed),
        .o_siren_on       (siren_on),
        .o_digit_position (digit_position),
        .o_digit_value    (digit_value),
        .o_code_accepted  (code_accepted),
        .o_code_rejected  (code_rejected),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata)
    );

    // The 8 ns clock runs for the whole simulation.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Ticks waiting to be offered to the block, and the status words that
    // the accepted ticks are expected to produce, oldest first.
    t_tick   tick_q[$];
    t_result status_q[$];

    int errors = 0;
    int result_count = 0;
    int pushed = 0;

    // Shadow copy of the controller: configuration first, then the three
    // state machines and the pending event flags that feed them.
    logic [3:0]  key [3];
    logic [15:0] hold_limit;
    logic [7:0]  gap_limit;

    logic        lamp_lit;
    logic [15:0] lamp_age;
    logic        armed;
    logic        siren;
    logic        want_code;
    logic        want_light;
    logic        seen_lamp;
    logic        seen_alarm;
    logic        code_ok;
    logic [3:0]  digits [3];
    logic [1:0]  digit_pos;
    logic [7:0]  press_age;
    logic        entry_live;

    // Advances the shadow state by one tick and returns the status word the
    // block must report for it. The machines run in the order light, code,
    // alarm, and each one consumes the pending flags its transition uses.
    function automatic t_result next_status(t_tick t);
        t_result r;
        logic [1:0] p;
        logic code_match;
        r = '0;
        if (t.code_press) want_code = 1'b1;
        if (t.light_press) want_light = 1'b1;
        if (t.presence_seen) begin
            seen_lamp = 1'b1;
            seen_alarm = 1'b1;
        end
        // Both timers count up at the start of the tick (the lamp timer only while lit) and stick at their maximum.
        if (lamp_lit && lamp_age != LAMP_ELAPSED_MAX) lamp_age++;
        if (press_age != PRESS_ELAPSED_MAX) press_age++;

        // Light: the button toggles a lit lamp off; presence, or the button
        // on a dark lamp, (re)lights it; otherwise the hold time runs out.
        if (lamp_lit && want_light) begin
            lamp_lit = 1'b0;
            want_light = 1'b0;
        end else if (seen_lamp || (!lamp_lit && want_light)) begin
            lamp_lit = 1'b1;
            seen_lamp = 1'b0;
            want_light = 1'b0;
            lamp_age = '0;
        end else if (lamp_lit && lamp_age > hold_limit) begin
            lamp_lit = 1'b0;
            want_light = 1'b0;
        end

        // Code entry: a press steps the digit with wrap from nine to zero; a
        // long enough pause after a press closes the digit, and after the
        // last one the whole code is compared and the entry is cleared.
        p = (digit_pos > LAST_POS) ? LAST_POS : digit_pos;
        if (want_code) begin
            digits[p] = (digits[p] < DIGIT_MAX) ? digits[p] + 4'd1 : 4'd0;
            want_code = 1'b0;
            press_age = '0;
            code_ok = 1'b0;
            entry_live = 1'b1;
        end else if (entry_live && press_age > gap_limit) begin
            if (p < LAST_POS) begin
                digit_pos = p + 2'd1;
                code_ok = 1'b0;
                entry_live = 1'b0;
            end else begin
                code_match = digits[0] == key[0] && digits[1] == key[1] &&
                             digits[2] == key[2];
                digit_pos = '0;
                digits[0] = '0;
                digits[1] = '0;
                digits[2] = '0;
                entry_live = 1'b0;
                code_ok = code_match;
                r.code_accepted = code_match;
                r.code_rejected = !code_match;
            end
        end

        // Alarm: a good code arms; once armed, presence wins over a code and
        // sets the siren, and a good code with no presence pending disarms.
        if (!armed) begin
            if (code_ok) begin
                armed = 1'b1;
                seen_alarm = 1'b0;
                code_ok = 1'b0;
            end
        end else if (seen_alarm) begin
            siren = 1'b1;
            seen_alarm = 1'b0;
        end else if (code_ok) begin
            armed = 1'b0;
            siren = 1'b0;
            seen_alarm = 1'b0;
            code_ok = 1'b0;
        end

        p = (digit_pos > LAST_POS) ? LAST_POS : digit_pos;
        r.light_on = lamp_lit;
        r.alarm_armed = armed;
        r.siren_on = siren;
        r.digit_position = digit_pos;
        r.digit_value = digits[p];
        return r;
    endfunction

    // Every mismatch goes through here; only the first few are printed so a
    // badly broken block cannot flood the log, but all of them are counted.
    task automatic report_mismatch(string msg);
        if (errors < 40) $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                      result_count, name, got, want));
        end
    endtask

    // Sender. Items leave the queue in bursts of random length separated by
    // random gaps, and now and then a long burst runs with no gap at all.
    // The prediction is taken at the edge that accepts the transaction.
    t_tick cur_tick;
    logic  next_valid;
    int    burst_left = 0;
    int    gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_valid <= 1'b0;
        end else begin
            next_valid = tick_valid;
            if (tick_valid && !tick_stall) begin
                status_q.push_back(next_status(cur_tick));
                next_valid = 1'b0;
            end
            if (!next_valid && gap_left == 0 && tick_q.size() != 0) begin
                cur_tick = tick_q.pop_front();
                next_valid = 1'b1;
                code_press <= cur_tick.code_press;
                light_press <= cur_tick.light_press;
                presence_seen <= cur_tick.presence_seen;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(100, 300);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end else if (!next_valid) begin
                if (gap_left > 0) gap_left--;
                // The payload is junk while valid is low; the block must ignore it.
                code_press <= 1'($urandom_range(0, 1));
                light_press <= 1'($urandom_range(0, 1));
                presence_seen <= 1'($urandom_range(0, 1));
            end
            tick_valid <= next_valid;
        end
    end

    // Receiver stall pattern. The mode is drawn at random from four: no stall,
    // coin flips, a fixed one-in-three pattern, or long stretches that flip
    // only rarely.
    int stall_cycle = 0;
    int stall_mode = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_stall <= 1'b0;
        end else begin
            stall_cycle++;
            if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: begin
                    result_stall <= 1'b0;
                end
                1: begin
                    result_stall <= 1'($urandom_range(0, 1));
                end
                2: begin
                    result_stall <= (stall_cycle % 3) == 0;
                end
                default: begin
                    if ($urandom_range(0, 5) == 0) result_stall <= !result_stall;
                end
            endcase
        end
    end

    // Monitor. Each result transaction is compared field by field with the
    // oldest prediction; a result with nothing predicted is a failure too.
    t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && result_valid && !result_stall) begin
            if (status_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_count));
            end else begin
                want = status_q.pop_front();
                check_field("light_on", 4'(light_on), 4'(want.light_on));
                check_field("alarm_armed", 4'(alarm_armed), 4'(want.alarm_armed));
                check_field("siren_on", 4'(siren_on), 4'(want.siren_on));
                check_field("digit_position", 4'(digit_position), 4'(want.digit_position));
                check_field("digit_value", digit_value, want.digit_value);
                check_field("code_accepted", 4'(code_accepted), 4'(want.code_accepted));
                check_field("code_rejected", 4'(code_rejected), 4'(want.code_rejected));
            end
            result_count++;
        end
    end

    function automatic logic rare();
        return $urandom_range(0, 5) == 0;
    endfunction

    task automatic push_tick(logic c, logic l, logic p);
        t_tick t;
        t.code_press = c;
        t.light_press = l;
        t.presence_seen = p;
        tick_q.push_back(t);
        pushed++;
    endtask

    // Blocks until every queued tick has been accepted and every predicted
    // result has come back, then lets the pipeline settle.
    task automatic wait_idle();
        while (tick_q.size() != 0 || tick_valid || status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Register writes are issued one per cycle; the shadow copy takes the
    // value at once since no tick is in flight while this runs.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SECRET_FIRST:     key[0] = data[3:0];
            REG_SECRET_SECOND:    key[1] = data[3:0];
            REG_SECRET_THIRD:     key[2] = data[3:0];
            REG_LIGHT_HOLD_TICKS: hold_limit = data;
            REG_PRESS_GAP_TICKS:  gap_limit = data[7:0];
            default: ;
        endcase
    endtask

    // Writes all five registers with junk in the unused upper bits, plus one
    // write to an unused index that the block must ignore.
    task automatic set_config(logic [3:0] k0, logic [3:0] k1, logic [3:0] k2,
                              logic [15:0] hold, logic [7:0] gap);
        write_reg(REG_SECRET_FIRST, {12'($urandom), k0});
        write_reg(REG_SECRET_SECOND, {12'($urandom), k1});
        write_reg(REG_SECRET_THIRD, {12'($urandom), k2});
        write_reg(REG_LIGHT_HOLD_TICKS, hold);
        write_reg(REG_PRESS_GAP_TICKS, {8'($urandom), gap});
        write_reg(3'($urandom_range(5, 7)), 16'($urandom));
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Queues a complete code entry for the current secret: each digit is
    // pressed the right number of times (ten presses for a zero), with short
    // pauses that stay within the gap, then a pause that closes the digit.
    // A corrupted entry enters one digit one step higher and is rejected.
    task automatic push_code(logic corrupt);
        int bad;
        int n;
        bad = corrupt ? $urandom_range(0, 2) : 3;
        for (int d = 0; d < 3; d++) begin
            n = key[d] % 10;
            if (n == 0) n = 10;
            if (d == bad) n = n % 10 + 1;
            for (int k = 0; k < n; k++) begin
                push_tick(1'b1, rare(), rare());
                if (k < n - 1) begin
                    repeat ($urandom_range(0, (gap_limit < 2) ? gap_limit : 2)) begin
                        push_tick(1'b0, rare(), rare());
                    end
                end
            end
            repeat (gap_limit + 1) push_tick(1'b0, rare(), rare());
        end
    endtask

    // One random phase: mostly well-formed code entries with light and
    // presence events sprinkled in, the rest noise and single presses that
    // are followed by a long pause. With a long gap only the latter fit.
    task automatic run_phase(int n_items);
        int start;
        start = pushed;
        while (pushed - start < n_items) begin
            if (gap_limit <= 12 && $urandom_range(0, 9) < 7) begin
                push_code($urandom_range(0, 4) == 0);
            end else if ($urandom_range(0, 3) == 0) begin
                push_tick(1'b1, rare(), rare());
                repeat (gap_limit + 40) push_tick(1'b0, rare(), rare());
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
        end
        wait_idle();
    endtask

    initial begin
        // Shadow state after reset: everything clear, code 7-5-9, hold 25, gap 5.
        key[0] = SECRET_FIRST_RST;
        key[1] = SECRET_SECOND_RST;
        key[2] = SECRET_THIRD_RST;
        hold_limit = LIGHT_HOLD_TICKS_RST;
        gap_limit = PRESS_GAP_TICKS_RST;
        lamp_lit = 1'b0;
        lamp_age = '0;
        armed = 1'b0;
        siren = 1'b0;
        want_code = 1'b0;
        want_light = 1'b0;
        seen_lamp = 1'b0;
        seen_alarm = 1'b0;
        code_ok = 1'b0;
        digits[0] = '0;
        digits[1] = '0;
        digits[2] = '0;
        digit_pos = '0;
        press_age = '0;
        entry_live = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with code 1-2-1, hold 2 and gap 0 so that every
        // machine moves within a couple of ticks.
        set_config(4'd1, 4'd2, 4'd1, 16'd2, 8'd0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b1);    // presence lights the lamp
        push_tick(1'b0, 1'b1, 1'b0);    // button turns it off
        push_tick(1'b0, 1'b1, 1'b0);    // button turns it on again
        push_tick(1'b0, 1'b0, 1'b1);    // presence restarts the hold timer
        repeat (3) push_tick(1'b0, 1'b0, 1'b0);   // hold runs out
        push_tick(1'b1, 1'b0, 1'b0);    // first digit 1
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);    // second digit 2
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);    // third digit 1
        push_tick(1'b0, 1'b0, 1'b0);    // code accepted, alarm arms
        push_tick(1'b0, 1'b0, 1'b1);    // presence while armed sets the siren
        push_tick(1'b1, 1'b1, 1'b1);    // all three events in one tick
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);    // code accepted again, alarm disarms
        wait_idle();

        // Random phases over several settings, the extremes first: all-zero
        // and all-nine codes, a code no entry can match because its digits
        // are above nine, and timers so long they never expire.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_config(4'd0, 4'd0, 4'd0, 16'd0, 8'd0);
                1: set_config(4'd9, 4'd9, 4'd9, 16'd1, 8'd1);
                2: set_config(4'hA, 4'hF, 4'hC, 16'd5, 8'd2);
                3: set_config(4'd3, 4'd8, 4'd1, 16'hFFFF, 8'hFF);
                default: begin
                    set_config(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                               4'($urandom_range(0, 9)), 16'($urandom_range(1, 40)),
                               8'($urandom_range(0, 6)));
                end
            endcase
            run_phase(100);
        end

        // Let any late result show up before the verdict.
        repeat (8) @(posedge i_clk);
        if (status_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived", status_q.size()));
        end
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every stall
    // and gap at its longest.
    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
